[src/icf_pkg.sv]
// Shared constants and types for the instruction cache fetch core.
// Used by icf_line_store, instruction_cache_fetch_core and the bench; no dependencies.
package icf_pkg;

   localparam int WORD_BITS      = 32;
   localparam int WORDS_PER_LINE = 4;
   localparam int OFFSET_BITS    = 2;
   localparam int TAG_BITS       = 20;
   localparam int TAG_LSB        = 12;
   localparam int LINE_LSB       = 4;

   localparam logic [2:0]  UNCACHED_TOP  = 3'b101;
   localparam logic [2:0]  MAPPED_TOP    = 3'b110;
   localparam logic [31:0] ROM_START     = 32'h1FC0_0000;
   localparam logic [31:0] ROM_END       = 32'h1FC8_0000;
   localparam logic [31:0] LOW29_MASK    = 32'h1FFF_FFFF;
   localparam logic [7:0]  ROM_COST_INIT = 8'd24;

   typedef logic [WORDS_PER_LINE-1:0][WORD_BITS-1:0] line_words_type;

   // One line as read back from the store.
   typedef struct packed {
      logic [TAG_BITS-1:0]       tag;
      logic [WORDS_PER_LINE-1:0] valid;
      line_words_type            words;
   } icf_entry_type;

   // One line update after a miss.
   typedef struct packed {
      logic [TAG_BITS-1:0]       tag;
      logic [WORDS_PER_LINE-1:0] valid;
      logic [WORDS_PER_LINE-1:0] bank_we;
      line_words_type            words;
   } icf_fill_type;

endpackage

[src/icf_line_store.sv]
// Tag/valid memory and word banks of the cache, with a clearing sweep after reset.
// Depends on icf_pkg.
module icf_line_store
   import icf_pkg::*;
#(
   parameter int NUM_LINES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         read_en,
   input  logic [$clog2(NUM_LINES)-1:0] read_line,
   output icf_entry_type                read_entry,
   input  logic                         fill_en,
   input  logic [$clog2(NUM_LINES)-1:0] fill_line,
   input  icf_fill_type                 fill,
   output logic                         clear_busy
);

   localparam int LINE_BITS = $clog2(NUM_LINES);
   localparam int META_BITS = TAG_BITS + WORDS_PER_LINE;
   localparam logic [LINE_BITS-1:0] LAST_LINE = LINE_BITS'(NUM_LINES - 1);

   logic [META_BITS-1:0] meta_mem [NUM_LINES];
   logic [META_BITS-1:0] rd_meta_ff;
   logic [LINE_BITS-1:0] clear_idx_ff;
   logic                 clear_busy_ff;
   line_words_type       rd_words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
      end else if (clear_busy_ff) begin
         if (clear_idx_ff == LAST_LINE) begin
            clear_busy_ff <= 1'b0;
         end
         clear_idx_ff <= clear_idx_ff + 1'b1;
      end
   end

   // Clearing owns the write port until the sweep ends.
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         meta_mem[clear_idx_ff] <= '0;
      end else if (fill_en) begin
         meta_mem[fill_line] <= {fill.tag, fill.valid};
      end
      if (read_en) begin
         rd_meta_ff <= meta_mem[read_line];
      end
   end

   for (genvar j = 0; j < WORDS_PER_LINE; j++) begin : g_bank
      logic [WORD_BITS-1:0] bank_mem [NUM_LINES];

      always_ff @(posedge clock) begin
         if (fill_en && fill.bank_we[j]) begin
            bank_mem[fill_line] <= fill.words[j];
         end
         if (read_en) begin
            rd_words_ff[j] <= bank_mem[read_line];
         end
      end
   end

   assign read_entry.tag   = rd_meta_ff[META_BITS-1 -: TAG_BITS];
   assign read_entry.valid = rd_meta_ff[WORDS_PER_LINE-1:0];
   assign read_entry.words = rd_words_ff;
   assign clear_busy       = clear_busy_ff;

endmodule

[src/instruction_cache_fetch_core.sv]
// Direct-mapped instruction cache fetch core: lookup, fill and ROM wait accounting.
// Depends on icf_pkg and icf_line_store.
//
// Usage: each fetch word on the req_ channel carries a virtual address, a
// charge flag and the four memory words of the 16-byte line it falls in.
// Every fetch yields exactly one rsp_ word: the instruction, a hit flag, the
// number of memory words read and the ROM wait cycles charged. Addresses
// with top bits 101 bypass the cache; others are looked up in NUM_LINES
// lines of four words, and a miss fills from the missed word to line end.
// On acceptance the tag and word memories are read into the lookup stage;
// when the lookup advances, compare, fill and result are registered and
// rsp_valid is set.
// Throughput is one fetch per cycle while rsp_ready holds high; the single
// memory read port sets it; the previous fill is forwarded to the next lookup.
// After reset req_ready stays low while the valid bits are cleared, one line
// per cycle; csr_ writes are taken throughout.
// When rsp_ready is low the result register holds, the lookup stage holds
// behind it, and req_ready drops once both are full.
module instruction_cache_fetch_core
   import icf_pkg::*;
#(
   parameter int NUM_LINES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_fetch_address,
   input  logic        req_charge_cycles,
   input  logic [31:0] req_mem_word0,
   input  logic [31:0] req_mem_word1,
   input  logic [31:0] req_mem_word2,
   input  logic [31:0] req_mem_word3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_instruction,
   output logic        rsp_cache_hit,
   output logic [2:0]  rsp_words_read,
   output logic [9:0]  rsp_extra_cycles
);

   localparam int LINE_BITS = $clog2(NUM_LINES);

   logic [7:0]           rom_cost_ff;
   logic                 s1_valid_ff;
   logic [31:0]          s1_address_ff;
   logic                 s1_charge_ff;
   line_words_type       s1_mem_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_instruction_ff;
   logic                 rsp_hit_ff;
   logic [2:0]           rsp_words_ff;
   logic [9:0]           rsp_extra_ff;
   logic                 last_fill_en_ff;
   logic [LINE_BITS-1:0] last_line_ff;
   icf_fill_type         last_fill_ff;

   logic                 accept;
   logic                 advance;
   logic                 clear_busy;
   icf_entry_type        mem_entry;
   logic [LINE_BITS-1:0] req_line;
   logic [31:0]          req_phys;
   logic [31:0]          phys;
   logic [LINE_BITS-1:0] line;
   logic [TAG_BITS-1:0]  tag;
   logic [OFFSET_BITS-1:0] word_sel;
   logic                 bypass;
   logic                 forward;
   logic [TAG_BITS-1:0]  cur_tag;
   logic [WORDS_PER_LINE-1:0] cur_valid;
   line_words_type       cur_words;
   logic                 hit;
   logic                 fill_en;
   icf_fill_type         fill;
   logic [WORDS_PER_LINE-1:0] line_mask;
   logic                 in_rom;
   logic [31:0]          rsp_instruction_in;
   logic [2:0]           rsp_words_in;
   logic [9:0]           rsp_extra_in;

   function automatic logic [31:0] to_physical(input logic [31:0] va);
      if (va[31:29] < MAPPED_TOP) begin
         return va & LOW29_MASK;
      end
      return va;
   endfunction

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clear_busy && (!s1_valid_ff || advance);
   assign accept    = req_valid && req_ready;

   assign req_phys = to_physical(req_fetch_address);
   assign req_line = req_phys[LINE_LSB +: LINE_BITS];

   icf_line_store #(
      .NUM_LINES (NUM_LINES)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .read_en    (accept),
      .read_line  (req_line),
      .read_entry (mem_entry),
      .fill_en    (fill_en),
      .fill_line  (line),
      .fill       (fill),
      .clear_busy (clear_busy)
   );

   // Lookup stage.
   assign word_sel = s1_address_ff[3:2];
   assign bypass   = s1_address_ff[31:29] == UNCACHED_TOP;
   assign phys     = to_physical(s1_address_ff);
   assign line     = phys[LINE_LSB +: LINE_BITS];
   assign tag      = phys[31:TAG_LSB];

   // The fill written at the edge this lookup read the store is not in the
   // read data; take it from the last-fill registers.
   assign forward = last_fill_en_ff && (last_line_ff == line);

   always_comb begin
      cur_tag   = mem_entry.tag;
      cur_valid = mem_entry.valid;
      cur_words = mem_entry.words;
      if (forward) begin
         cur_tag   = last_fill_ff.tag;
         cur_valid = last_fill_ff.valid;
         for (int j = 0; j < WORDS_PER_LINE; j++) begin
            if (last_fill_ff.bank_we[j]) begin
               cur_words[j] = last_fill_ff.words[j];
            end
         end
      end
   end

   assign hit       = !bypass && (cur_tag == tag) && cur_valid[word_sel];
   assign fill_en   = advance && !bypass && !hit;
   assign line_mask = {WORDS_PER_LINE{1'b1}} << word_sel;

   assign fill.tag     = tag;
   assign fill.valid   = line_mask;
   assign fill.bank_we = line_mask;
   assign fill.words   = s1_mem_ff;

   assign in_rom = (phys >= ROM_START) && (phys < ROM_END);

   always_comb begin
      if (hit) begin
         rsp_words_in = 3'd0;
      end else if (bypass) begin
         rsp_words_in = 3'd1;
      end else begin
         rsp_words_in = 3'(WORDS_PER_LINE) - {1'b0, word_sel};
      end
      rsp_instruction_in = hit ? cur_words[word_sel] : s1_mem_ff[word_sel];
      rsp_extra_in       = '0;
      if (s1_charge_ff && in_rom) begin
         rsp_extra_in = {2'b00, rom_cost_ff} * {7'b0000000, rsp_words_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_cost_ff     <= ROM_COST_INIT;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         last_fill_en_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            rom_cost_ff <= csr_write_data;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fill_en) begin
            last_fill_en_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_address_ff <= req_fetch_address;
         s1_charge_ff  <= req_charge_cycles;
         s1_mem_ff     <= {req_mem_word3, req_mem_word2, req_mem_word1, req_mem_word0};
      end
      if (advance) begin
         rsp_instruction_ff <= rsp_instruction_in;
         rsp_hit_ff         <= hit;
         rsp_words_ff       <= rsp_words_in;
         rsp_extra_ff       <= rsp_extra_in;
      end
      if (fill_en) begin
         last_line_ff <= line;
         last_fill_ff <= fill;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_instruction  = rsp_instruction_ff;
   assign rsp_cache_hit    = rsp_hit_ff;
   assign rsp_words_read   = rsp_words_ff;
   assign rsp_extra_cycles = rsp_extra_ff;

   // A hit reads no memory and is never charged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cache_hit |-> rsp_words_read == 3'd0 && rsp_extra_cycles == 10'd0)
      else $error("hit result reports memory reads or wait cycles");

   // A miss or bypass reads between one and four words.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cache_hit |-> rsp_words_read != 3'd0 && rsp_words_read <= 3'd4)
      else $error("miss result has an impossible word count");

   // No fetch enters or fills while the valid bits are being cleared.
   assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !s1_valid_ff && !fill_en)
      else $error("lookup active during clearing sweep");

   // A lookup blocked by a full result register stays put.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_address_ff))
      else $error("stalled lookup lost or changed");

endmodule

[bench/icf_fetch_checker.sv]
// Fetch checker for instruction_cache_fetch_core: mirrors the cache state,
// predicts each fetch result and compares it with the rsp_ channel.
// Depends on icf_pkg for the address constants and the line word type.
module icf_fetch_checker
   import icf_pkg::*;
#(
   parameter int NUM_LINES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_fetch_address,
   input  logic        req_charge_cycles,
   input  logic [31:0] req_mem_word0,
   input  logic [31:0] req_mem_word1,
   input  logic [31:0] req_mem_word2,
   input  logic [31:0] req_mem_word3,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_instruction,
   input  logic        rsp_cache_hit,
   input  logic [2:0]  rsp_words_read,
   input  logic [9:0]  rsp_extra_cycles,
   output int          error_count,
   output int          outstanding
);

   typedef struct packed {
      logic [31:0] instruction;
      logic        cache_hit;
      logic [2:0]  words_read;
      logic [9:0]  extra_cycles;
   } fetch_result_type;

   fetch_result_type expected_fetches[$];

   logic [TAG_BITS-1:0]       shadow_tag   [NUM_LINES];
   logic [WORDS_PER_LINE-1:0] shadow_valid [NUM_LINES];
   logic [WORD_BITS-1:0]      shadow_data  [NUM_LINES*WORDS_PER_LINE];
   logic [7:0]                rom_cost;

   function automatic logic [9:0] rom_wait(logic [31:0] pa, logic [2:0] words, logic charge);
      logic [15:0] product;
      if (!charge || pa < ROM_START || pa >= ROM_END) begin
         return '0;
      end
      product = rom_cost * words;
      return product[9:0];
   endfunction

   // Predict one fetch and update the shadow cache the way the block does.
   function automatic fetch_result_type predict_fetch(logic [31:0] addr, logic charge,
                                                      line_words_type mem);
      fetch_result_type r;
      logic [31:0]      pa;
      logic [1:0]       word;
      int               line;
      int               base;
      int               j;
      r    = '0;
      word = addr[3:2];
      if (addr[31:29] == UNCACHED_TOP) begin
         r.instruction  = mem[word];
         r.words_read   = 3'd1;
         r.extra_cycles = rom_wait(addr & LOW29_MASK, 3'd1, charge);
         return r;
      end
      pa   = (addr[31:29] < MAPPED_TOP) ? (addr & LOW29_MASK) : addr;
      line = int'((pa >> LINE_LSB) & (NUM_LINES - 1));
      base = line * WORDS_PER_LINE;
      if (shadow_tag[line] == pa[31:TAG_LSB] && shadow_valid[line][word]) begin
         r.instruction = shadow_data[base + word];
         r.cache_hit   = 1'b1;
         return r;
      end
      // miss: retag, drop words below the missed one, fill from it to line end
      shadow_tag[line] = pa[31:TAG_LSB];
      for (j = 0; j < WORDS_PER_LINE; j++) begin
         if (j < word) begin
            shadow_valid[line][j] = 1'b0;
         end else begin
            shadow_data[base + j] = mem[j];
            shadow_valid[line][j] = 1'b1;
         end
      end
      r.instruction  = mem[word];
      r.words_read   = 3'(WORDS_PER_LINE - word);
      r.extra_cycles = rom_wait({pa[31:4], word, 2'b00}, r.words_read, charge);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("icf_fetch_checker: %s: got %0h expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   always @(posedge clock) begin : watch
      fetch_result_type want;
      int               i;
      if (reset) begin
         for (i = 0; i < NUM_LINES; i++) begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = '0;
         end
         rom_cost    = ROM_COST_INIT;
         error_count = 0;
         expected_fetches.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_fetches.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_instruction, '0);
            end else begin
               want = expected_fetches.pop_front();
               if (rsp_instruction !== want.instruction)
                  report_mismatch("instruction", rsp_instruction, want.instruction);
               if (rsp_cache_hit !== want.cache_hit)
                  report_mismatch("cache_hit", 32'(rsp_cache_hit), 32'(want.cache_hit));
               if (rsp_words_read !== want.words_read)
                  report_mismatch("words_read", 32'(rsp_words_read), 32'(want.words_read));
               if (rsp_extra_cycles !== want.extra_cycles)
                  report_mismatch("extra_cycles", 32'(rsp_extra_cycles),
                                  32'(want.extra_cycles));
            end
         end
         if (csr_write_enable) begin
            rom_cost = csr_write_data;
         end
         if (req_valid && req_ready) begin
            expected_fetches.push_back(predict_fetch(req_fetch_address, req_charge_cycles,
               {req_mem_word3, req_mem_word2, req_mem_word1, req_mem_word0}));
         end
      end
      outstanding <= expected_fetches.size();
   end

endmodule

[bench/tb_instruction_cache_fetch_core.sv]
// Top of the instruction cache fetch bench: clock, reset, fetch stimulus,
// response stalls and the verdict. Depends on icf_pkg, icf_fetch_checker
// and instruction_cache_fetch_core.
module tb_instruction_cache_fetch_core;
   import icf_pkg::*;

   localparam int NUM_LINES   = 256;
   localparam int PHASE_ITEMS = 250;
   localparam int NUM_PHASES  = 7;
   localparam int NUM_DIRECTED = 20;

   localparam logic [31:0] DIRECTED_ADDR [NUM_DIRECTED] = '{
      32'h0000_0000, 32'h0000_0004, 32'h0000_000B, 32'h8000_000C,
      32'h0000_1008, 32'h0000_1000, 32'hBFC0_0004, 32'hBFC0_0004,
      32'hBFC8_0000, 32'h9FC7_FFFC, 32'h1FC0_0000, 32'h1FC0_0009,
      32'hFFFF_FFFF, 32'hC000_0010, 32'h1FBF_FFF0, 32'h1FC8_0000,
      32'hA000_0000, 32'h7FFF_FFFD, 32'hFFFF_FFFC, 32'h0000_0026
   };
   localparam bit DIRECTED_CHARGE [NUM_DIRECTED] = '{
      1, 1, 1, 1, 1, 1, 1, 0, 1, 1,
      1, 1, 0, 1, 1, 1, 1, 1, 1, 1
   };

   logic        clock;
   logic        reset            = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data   = '0;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [31:0] req_fetch_address = '0;
   logic        req_charge_cycles = 1'b0;
   logic [31:0] req_mem_word0    = '0;
   logic [31:0] req_mem_word1    = '0;
   logic [31:0] req_mem_word2    = '0;
   logic [31:0] req_mem_word3    = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [31:0] rsp_instruction;
   logic        rsp_cache_hit;
   logic [2:0]  rsp_words_read;
   logic [9:0]  rsp_extra_cycles;

   int          mismatch_count;
   int          results_pending;

   int          burst_left = 0;
   int          run_left   = 0;
   logic [31:0] fetch_pc   = '0;
   int          stall_mode = 0;
   int          stall_left = 0;

   instruction_cache_fetch_core #(.NUM_LINES(NUM_LINES)) i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_fetch_address (req_fetch_address),
      .req_charge_cycles (req_charge_cycles),
      .req_mem_word0     (req_mem_word0),
      .req_mem_word1     (req_mem_word1),
      .req_mem_word2     (req_mem_word2),
      .req_mem_word3     (req_mem_word3),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_instruction   (rsp_instruction),
      .rsp_cache_hit     (rsp_cache_hit),
      .rsp_words_read    (rsp_words_read),
      .rsp_extra_cycles  (rsp_extra_cycles)
   );

   icf_fetch_checker #(.NUM_LINES(NUM_LINES)) i_fetch_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_fetch_address (req_fetch_address),
      .req_charge_cycles (req_charge_cycles),
      .req_mem_word0     (req_mem_word0),
      .req_mem_word1     (req_mem_word1),
      .req_mem_word2     (req_mem_word2),
      .req_mem_word3     (req_mem_word3),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_instruction   (rsp_instruction),
      .rsp_cache_hit     (rsp_cache_hit),
      .rsp_words_read    (rsp_words_read),
      .rsp_extra_cycles  (rsp_extra_cycles),
      .error_count       (mismatch_count),
      .outstanding       (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_instruction_cache_fetch_core: FAIL");
      $finish;
   end

   // Receiver: switch at random between four stall patterns.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= ($urandom_range(0, 1) == 0);
         end
         2: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= (stall_left % 3 == 0);
         end
      endcase
   end

   function automatic line_words_type random_line();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // Present one fetch word and hold it until accepted; bursts with gaps.
   task automatic send_fetch(input logic [31:0] addr, input logic charge,
                             input line_words_type mem);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_fetch_address <= addr;
      req_charge_cycles <= charge;
      req_mem_word0     <= mem[0];
      req_mem_word1     <= mem[1];
      req_mem_word2     <= mem[2];
      req_mem_word3     <= mem[3];
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Mostly sequential runs through a small working set, with loop-backs,
   // segment aliases and ROM boundaries; the rest is raw noise.
   task automatic send_random_fetch();
      logic [31:0] addr;
      logic [31:0] phys;
      logic [2:0]  top;
      logic        charge;
      if ($urandom_range(0, 99) < 12) begin
         addr = $urandom;
      end else begin
         if (run_left == 0) begin
            case ($urandom_range(0, 5))
               0, 1: begin
                  phys = (32'($urandom_range(0, 3)) << 12) | (32'($urandom_range(0, 63)) << 4)
                         | (32'($urandom_range(0, 3)) << 2);
                  top  = 3'($urandom_range(0, 4));
               end
               2: begin
                  phys = ROM_START + (($urandom_range(0, 1) == 0) ? 32'h0 : 32'h7_F000)
                         + (32'($urandom_range(0, 255)) << 4) + (32'($urandom_range(0, 3)) << 2);
                  top  = 3'($urandom_range(0, 4));
               end
               3: begin
                  phys = ROM_START + (($urandom_range(0, 1) == 0) ? 32'h7_FF00 : 32'h0)
                         + (32'($urandom_range(0, 15)) << 4);
                  top  = UNCACHED_TOP;
               end
               4: begin
                  phys = (32'($urandom_range(0, 3)) << 12) | (32'($urandom_range(0, 63)) << 4);
                  top  = 3'($urandom_range(6, 7));
               end
               default: begin
                  phys = $urandom;
                  top  = phys[31:29];
               end
            endcase
            fetch_pc = {top, phys[28:2], 2'b00};
            run_left = $urandom_range(1, 24);
         end else if ($urandom_range(0, 15) == 0) begin
            fetch_pc = fetch_pc - 32'(16 * $urandom_range(1, 4));
         end
         addr = fetch_pc | 32'($urandom_range(0, 3));
         fetch_pc += 4;
         run_left--;
      end
      charge = ($urandom_range(0, 3) != 0);
      send_fetch(addr, charge, random_line());
   endtask

   // Hold until every expected result has come back.
   task automatic drain_results();
      do @(posedge clock); while (results_pending != 0);
   endtask

   initial begin
      int          i;
      int          phase;
      logic [7:0]  cost;
      line_words_type mem;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed fetches run with the reset value of the ROM cost
      for (i = 0; i < NUM_DIRECTED; i++) begin
         if (i == 0) mem = '0;
         else if (i == 4) mem = '1;
         else mem = random_line();
         send_fetch(DIRECTED_ADDR[i], DIRECTED_CHARGE[i], mem);
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               cost = 8'hFF;
            end
            1: begin
               cost = 8'h00;
            end
            4: begin
               cost = 8'h01;
            end
            default: begin
               cost = 8'($urandom_range(0, 255));
            end
         endcase
         req_valid <= 1'b0;
         drain_results();
         repeat (4) @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data   <= cost;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            send_random_fetch();
         end
      end

      req_valid <= 1'b0;
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_instruction_cache_fetch_core: PASS");
      end else begin
         $display("tb_instruction_cache_fetch_core: FAIL");
      end
      $finish;
   end

endmodule
